FILE: src/sec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sec_pkg: shared types and constants of the spherical Earth converter
// Holds the rotator data types, the reset radius, the rotator start gain and
// the elaboration-time generator for the arctangent step of each cell.
// ----------------------------------------------------------------------------
package sec_pkg;

	localparam int                  ATAN_ENTRIES = 40;
	localparam logic [23:0]         RADIUS_RESET = 24'd6378137;
	localparam logic signed [63:0]  CORDIC_X0    = 64'sd652032874 <<< 30;

	typedef struct packed {
		logic signed [63:0] x;
		logic signed [63:0] y;
		logic signed [63:0] z;
	} rot_t;

	typedef struct packed {
		logic signed [28:0] radius;
		logic               flip_lat;
		logic               flip_lon;
	} side_t;

	typedef struct packed {
		logic signed [31:0] x_pos;
		logic signed [31:0] y_pos;
		logic signed [31:0] z_pos;
	} res_t;

	// Restoring long division, used only while building constants.
	function automatic logic [63:0] long_div(logic [63:0] num, logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int k = 63; k >= 0; k--) begin
			rem = {rem[63:0], num[k]};
			quo = quo << 1;
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[0] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic logic [63:0] atan_recip_q61(logic [63:0] n);
		logic [63:0] p;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] term;
		p   = long_div(64'd1 << 61, n);
		pos = '0;
		neg = '0;
		for (int k = 0; k < 32; k++) begin
			if (p != 64'd0) begin
				term = long_div(p, 64'(2 * k + 1));
				if (k[0]) begin
					neg = neg + term;
				end else begin
					pos = pos + term;
				end
				p = long_div(p, n * n);
			end
		end
		return pos - neg;
	endfunction

	// Arctangent of 2^-idx in phase units, where 2^62 stands for pi.
	function automatic logic [63:0] atan_entry(int idx);
		logic [63:0] pi_q61;
		logic [63:0] p;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] term;
		logic [63:0] rem;
		logic [63:0] q;
		if (idx == 0) begin
			return 64'd1 << 60;
		end
		pi_q61 = 64'd16 * atan_recip_q61(64'd5) - 64'd4 * atan_recip_q61(64'd239);
		p   = 64'd1 << (61 - idx);
		pos = '0;
		neg = '0;
		for (int k = 0; k < 32; k++) begin
			if (p != 64'd0) begin
				term = long_div(p, 64'(2 * k + 1));
				if (k[0]) begin
					neg = neg + term;
				end else begin
					pos = pos + term;
				end
				p = (2 * idx < 62) ? (p >> (2 * idx)) : 64'd0;
			end
		end
		rem = pos - neg;
		q   = '0;
		for (int step = 0; step < 62; step++) begin
			rem = rem << 1;
			q   = q << 1;
			if (rem >= pi_q61) begin
				rem  = rem - pi_q61;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

endpackage

FILE: src/sec_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sec_if: item channels of the spherical Earth converter
// The position channel carries latitude, longitude and height; the result
// channel carries the Cartesian x, y and z coordinates.
// ----------------------------------------------------------------------------
interface sec_geo_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] latitude;
	logic signed [31:0] longitude;
	logic signed [27:0] height;

	modport source(output valid, latitude, longitude, height, input ready);
	modport sink(input valid, latitude, longitude, height, output ready);
endinterface

interface sec_ecef_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] x_pos;
	logic signed [31:0] y_pos;
	logic signed [31:0] z_pos;

	modport source(output valid, x_pos, y_pos, z_pos, input ready);
	modport sink(input valid, x_pos, y_pos, z_pos, output ready);
endinterface

FILE: src/sec_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sec_cell: one rotation step of the sine and cosine chain
// Rotates the latitude and the longitude vector by the arctangent of 2^-STAGE
// toward a zero residual angle and hands the result to the next cell.
// ----------------------------------------------------------------------------
module sec_cell #(
	parameter int STAGE = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             run,
	input  logic             in_valid,
	input  sec_pkg::rot_t    in_lat,
	input  sec_pkg::rot_t    in_lon,
	input  sec_pkg::side_t   in_side,
	output logic             out_valid,
	output sec_pkg::rot_t    out_lat,
	output sec_pkg::rot_t    out_lon,
	output sec_pkg::side_t   out_side
);

	localparam logic signed [63:0] ANGLE_STEP = sec_pkg::atan_entry(STAGE);

	function automatic sec_pkg::rot_t rotate(sec_pkg::rot_t v);
		logic signed [63:0] vx;
		logic signed [63:0] vy;
		logic signed [63:0] vz;
		logic signed [63:0] dx;
		logic signed [63:0] dy;
		sec_pkg::rot_t      o;
		vx = v.x;
		vy = v.y;
		vz = v.z;
		dx = vy >>> STAGE;
		dy = vx >>> STAGE;
		if (!vz[63]) begin
			o.x = vx - dx;
			o.y = vy + dy;
			o.z = vz - ANGLE_STEP;
		end else begin
			o.x = vx + dx;
			o.y = vy - dy;
			o.z = vz + ANGLE_STEP;
		end
		return o;
	endfunction

	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (run) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (run) begin
			out_lat  <= rotate(in_lat);
			out_lon  <= rotate(in_lon);
			out_side <= in_side;
		end
	end

	assign out_valid = valid_q;

endmodule

FILE: src/sec_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sec_scale: radius scaling and rounding
// Rounds the rotator outputs to Q30 sine and cosine, forms r*sin(lat) and
// r*cos(lat), splits the second product against cos and sin of longitude
// into partial products, and rounds the results to whole meters.
// ----------------------------------------------------------------------------
module sec_scale (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            run,
	input  logic            in_valid,
	input  sec_pkg::rot_t   in_lat,
	input  sec_pkg::rot_t   in_lon,
	input  sec_pkg::side_t  in_side,
	output logic            out_valid,
	output sec_pkg::res_t   out_res
);

	function automatic logic signed [31:0] round_q30(logic signed [63:0] v);
		logic signed [63:0] n;
		logic signed [63:0] t;
		n = {63'd0, v[63]};
		t = v + (64'sd1 <<< 29) - n;
		return t[61:30];
	endfunction

	logic [5:1] valid_q;

	logic signed [31:0]  cl_s1, sl_s1, co_s1, so_s1;
	logic signed [28:0]  r_s1;
	logic signed [60:0]  rc_s2, zp_s2;
	logic signed [31:0]  co_s2, so_s2;
	logic signed [64:0]  xl_s3, yl_s3;
	logic signed [60:0]  xh_s3, yh_s3;
	logic signed [31:0]  z_s3, z_s4, z_s5;
	logic signed [92:0]  xs_s4, ys_s4;
	logic signed [31:0]  x_s5, y_s5;

	logic signed [31:0]  cl_rnd;
	logic signed [31:0]  co_rnd;
	logic signed [60:0]  zp_neg;
	logic signed [60:0]  zp_sum;
	logic signed [92:0]  xs_neg, ys_neg;
	logic signed [92:0]  xs_sum, ys_sum;

	always_comb begin
		cl_rnd = round_q30(in_lat.x);
		co_rnd = round_q30(in_lon.x);
		zp_neg = {60'd0, zp_s2[60]};
		zp_sum = zp_s2 + (61'sd1 <<< 29) - zp_neg;
		xs_neg = {92'd0, xs_s4[92]};
		ys_neg = {92'd0, ys_s4[92]};
		xs_sum = xs_s4 + (93'sd1 <<< 59) - xs_neg;
		ys_sum = ys_s4 + (93'sd1 <<< 59) - ys_neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (run) begin
			valid_q <= {valid_q[4:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (run) begin
			cl_s1 <= in_side.flip_lat ? -cl_rnd : cl_rnd;
			sl_s1 <= round_q30(in_lat.y);
			co_s1 <= in_side.flip_lon ? -co_rnd : co_rnd;
			so_s1 <= round_q30(in_lon.y);
			r_s1  <= in_side.radius;

			rc_s2 <= r_s1 * cl_s1;
			zp_s2 <= r_s1 * sl_s1;
			co_s2 <= co_s1;
			so_s2 <= so_s1;

			xl_s3 <= $signed({1'b0, rc_s2[31:0]}) * co_s2;
			xh_s3 <= $signed(rc_s2[60:32]) * co_s2;
			yl_s3 <= $signed({1'b0, rc_s2[31:0]}) * so_s2;
			yh_s3 <= $signed(rc_s2[60:32]) * so_s2;
			z_s3  <= {zp_sum[60], zp_sum[60:30]};

			xs_s4 <= (93'(xh_s3) <<< 32) + 93'(xl_s3);
			ys_s4 <= (93'(yh_s3) <<< 32) + 93'(yl_s3);
			z_s4  <= z_s3;

			x_s5  <= xs_sum[91:60];
			y_s5  <= ys_sum[91:60];
			z_s5  <= z_s4;
		end
	end

	assign out_valid     = valid_q[5];
	assign out_res.x_pos = x_s5;
	assign out_res.y_pos = y_s5;
	assign out_res.z_pos = z_s5;

endmodule

FILE: src/sec_obuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sec_obuf: two-entry result buffer
// Decouples the result channel from the pipeline. The pipeline advances only
// while the buffer has a free entry, which is known from registered state.
// ----------------------------------------------------------------------------
module sec_obuf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sec_pkg::res_t  din,
	input  logic           pop_ready,
	output logic           out_valid,
	output sec_pkg::res_t  dout,
	output logic           room
);

	sec_pkg::res_t slot_q [2];
	logic [1:0]    count_q;
	logic          wr_q;
	logic          rd_q;
	logic          pop;

	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && pop_ready;
	assign room      = (count_q != 2'd2);
	assign dout      = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= din;
		end
	end

endmodule

FILE: src/spherical_earth_to_cartesian.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spherical_earth_to_cartesian: geodetic position to Earth-centered x, y, z
//
//   Channel   Direction  Contents
//   geo       in         latitude, longitude (2^31 = pi), height in meters
//   ecef      out        x_pos, y_pos, z_pos in meters, rounded
//   wr_en     in         write strobe for the sphere radius
//
// One item is accepted every cycle while the result buffer has room. Each item
// passes one folding stage, one rotation cell per stage and five scaling stages,
// then the two-entry result buffer.
// Reset clears all valid bits and sets the radius to the equatorial radius.
// A stalled result channel fills the buffer and then holds the whole pipeline.
// ----------------------------------------------------------------------------
module spherical_earth_to_cartesian #(
	parameter int ROTATION_STAGES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [23:0]        wr_data,
	sec_geo_if.sink            geo,
	sec_ecef_if.source         ecef
);

	localparam logic signed [32:0] QUARTER_TURN = 33'sd1 <<< 30;
	localparam logic signed [32:0] HALF_TURN    = 33'sd1 <<< 31;

	typedef struct packed {
		logic               flip;
		logic signed [32:0] ang;
	} fold_t;

	function automatic fold_t fold(logic signed [31:0] a);
		logic signed [32:0] w;
		fold_t              f;
		w      = 33'(a);
		f.flip = 1'b0;
		f.ang  = w;
		if (w > QUARTER_TURN) begin
			f.ang  = HALF_TURN - w;
			f.flip = 1'b1;
		end else if (w < -QUARTER_TURN) begin
			f.ang  = -HALF_TURN - w;
			f.flip = 1'b1;
		end
		return f;
	endfunction

	logic [23:0]        radius_q;
	logic               run;
	logic               room;
	fold_t              lat_fold;
	fold_t              lon_fold;
	logic signed [28:0] radius_sum;

	logic               valid_c [ROTATION_STAGES + 1];
	sec_pkg::rot_t      lat_c   [ROTATION_STAGES + 1];
	sec_pkg::rot_t      lon_c   [ROTATION_STAGES + 1];
	sec_pkg::side_t     side_c  [ROTATION_STAGES + 1];

	logic               valid_s0;
	logic               scale_valid;
	sec_pkg::res_t      scale_res;
	sec_pkg::res_t      out_res;

	assign run       = room;
	assign geo.ready = run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= sec_pkg::RADIUS_RESET;
		end else if (wr_en) begin
			radius_q <= wr_data;
		end
	end

	always_comb begin
		lat_fold   = fold(geo.latitude);
		lon_fold   = fold(geo.longitude);
		radius_sum = $signed({5'd0, radius_q}) + 29'(geo.height);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (run) begin
			valid_s0 <= geo.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (run) begin
			lat_c[0].x         <= sec_pkg::CORDIC_X0;
			lat_c[0].y         <= '0;
			lat_c[0].z         <= {lat_fold.ang, 31'd0};
			lon_c[0].x         <= sec_pkg::CORDIC_X0;
			lon_c[0].y         <= '0;
			lon_c[0].z         <= {lon_fold.ang, 31'd0};
			side_c[0].radius   <= radius_sum;
			side_c[0].flip_lat <= lat_fold.flip;
			side_c[0].flip_lon <= lon_fold.flip;
		end
	end

	assign valid_c[0] = valid_s0;

	for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_cell
		sec_cell #(
			.STAGE(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.run      (run),
			.in_valid (valid_c[i]),
			.in_lat   (lat_c[i]),
			.in_lon   (lon_c[i]),
			.in_side  (side_c[i]),
			.out_valid(valid_c[i + 1]),
			.out_lat  (lat_c[i + 1]),
			.out_lon  (lon_c[i + 1]),
			.out_side (side_c[i + 1])
		);
	end

	sec_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.run      (run),
		.in_valid (valid_c[ROTATION_STAGES]),
		.in_lat   (lat_c[ROTATION_STAGES]),
		.in_lon   (lon_c[ROTATION_STAGES]),
		.in_side  (side_c[ROTATION_STAGES]),
		.out_valid(scale_valid),
		.out_res  (scale_res)
	);

	sec_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (run && scale_valid),
		.din      (scale_res),
		.pop_ready(ecef.ready),
		.out_valid(ecef.valid),
		.dout     (out_res),
		.room     (room)
	);

	assign ecef.x_pos = out_res.x_pos;
	assign ecef.y_pos = out_res.y_pos;
	assign ecef.z_pos = out_res.z_pos;

endmodule

FILE: src/sec_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sec_checker: port-level checks of the spherical Earth converter
// Tracks the number of items in flight and checks it against the results
// shown and the pipeline capacity, plus flow control on both channels.
// ----------------------------------------------------------------------------
module sec_checker #(
	parameter int STAGES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	sec_geo_if.sink     geo,
	sec_ecef_if.source  ecef
);

	localparam int CNT_W = $clog2(STAGES + 9) + 1;

	logic [CNT_W-1:0] inflight_q;
	logic             acc;
	logic             del;

	assign acc = geo.valid && geo.ready;
	assign del = ecef.valid && ecef.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + CNT_W'(acc) - CNT_W'(del);
		end
	end

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		ecef.valid |-> inflight_q != '0)
		else $error("result shown with no item in flight");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(STAGES + 8))
		else $error("more items in flight than the pipeline holds");

	a_ready_recovers: assert property (@(posedge clk) disable iff (!arst_n)
		ecef.ready |=> geo.ready)
		else $error("input not ready after a cycle of output ready");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		ecef.valid && !ecef.ready |=> ecef.valid && $stable(ecef.x_pos)
			&& $stable(ecef.y_pos) && $stable(ecef.z_pos))
		else $error("stalled result changed");

endmodule

bind spherical_earth_to_cartesian sec_checker #(
	.STAGES(ROTATION_STAGES)
) u_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.geo   (geo),
	.ecef  (ecef)
);
